/* rtl/core/stdf_pkg.sv */
// Package for the sector track deframer: MFM sync and mask constants,
// store geometry, stream widths and the mode, phase and kind codes.
// No dependencies.
package stdf_pkg;

    localparam int MAX_SECTORS  = 11;
    localparam int SECTOR_LONGS = 128;
    localparam int HALF_LONGS   = SECTOR_LONGS + 2;
    localparam int STORE_LONGS  = MAX_SECTORS * SECTOR_LONGS;

    localparam int SEC_W   = 4;
    localparam int WIDX_W  = $clog2(HALF_LONGS);
    localparam int OFS_W   = $clog2(SECTOR_LONGS);
    localparam int ADDR_W  = $clog2(STORE_LONGS);
    localparam int CYL_W   = 8;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 8;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam logic [31:0] SYNC_WORD = 32'h4489_4489;
    localparam logic [15:0] SYNC_TAIL = 16'h2aaa;
    localparam logic [31:0] MFM_DATA  = 32'h5555_5555;

    localparam logic [1:0] MODE_BIT       = 2'd0;
    localparam logic [1:0] MODE_READ      = 2'd1;
    localparam logic [1:0] MODE_NEW_TRACK = 2'd2;

    localparam logic KIND_SECTOR = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic REG_CYLINDER     = 1'b0;
    localparam logic REG_SECTOR_COUNT = 1'b1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_TAIL,
        PH_ODD,
        PH_EVEN
    } phase_t;

endpackage

/* rtl/core/sector_track_deframer.sv */
// Sector track deframer top level: MFM sync hunt, odd/even long merge,
// checksum and header check, track store and read port.
// Depends on stdf_pkg.
//
// Usage:
//   s_axis carries one item per transfer. s_axis_tuser is the mode: raw bit,
//   read of a stored data long, or begin new track. Raw bits arrive MSB
//   first, one per transfer. m_axis returns sector accept events and read
//   answers; m_axis_tuser is the kind.
//   A result passes through the stage register and then the output register
//   before it leaves. Throughput: one item per cycle while not stalled.
//   The odd-half store is registered each cycle at the current long index;
//   the track store has one write port (decoded data) and one read port.
//   Reset (and a new-track item) clears the decoder state and the valid
//   mask; stored data is undefined until a sector is decoded again, but
//   it is never returned for a sector that is not valid.
//   Stall: one result waits in the stage register and one in the output
//   register; s_axis_tready falls only when both are held by the receiver.
//   Configuration writes (cylinder, sector count) take effect at once; the
//   user must make them while no item is in flight (the block does not enforce it).
module sector_track_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [stdf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // raw_bit[0], index_mark[1], read_index[12:2], zero pad
    input  logic [stdf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sector[3:0], data_word[35:4], valid_mask[46:36], first_sector[50:47],
    // all_valid[51], zero pad
    output logic [stdf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                           m_axis_tuser
);

    localparam int MS = stdf_pkg::MAX_SECTORS;

    // configuration
    logic [stdf_pkg::CYL_W-1:0] cylinder_reg;
    logic [stdf_pkg::CNT_W-1:0] sector_count_reg;

    // decoder state
    stdf_pkg::phase_t phase_reg, phase_next;
    logic [31:0]                 bit_window_reg, bit_window_next;
    logic [4:0]                  bit_in_word_reg, bit_in_word_next;
    logic [stdf_pkg::WIDX_W-1:0] word_index_reg, word_index_next;
    logic [31:0]                 running_sum_reg, running_sum_next;
    logic [7:0]                  header_sector_reg, header_sector_next;
    logic                        header_ok_reg, header_ok_next;
    logic [MS-1:0]               valid_reg, valid_next;
    logic [31:0]                 bits_since_index_reg, bits_since_index_next;
    logic [31:0]                 sync_offset_reg, sync_offset_next;
    logic [31:0]                 best_offset_reg, best_offset_next;
    logic [stdf_pkg::SEC_W-1:0]  first_sector_reg, first_sector_next;

    // memories
    logic [31:0] odd_mem [stdf_pkg::HALF_LONGS];
    logic [31:0] track_mem [stdf_pkg::STORE_LONGS];
    logic [31:0] odd_q;
    logic [31:0] track_q;
    logic        odd_we;
    logic        track_we;
    logic        track_re;
    logic [stdf_pkg::ADDR_W-1:0] track_waddr;

    // result stage and output register
    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_kind_reg;
    logic [stdf_pkg::SEC_W-1:0]  s1_sector_reg;
    logic                        s1_rd_ok_reg;
    logic [MS-1:0]               s1_mask_reg;
    logic [stdf_pkg::SEC_W-1:0]  s1_first_reg;
    logic                        s1_all_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [stdf_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                        out_kind_reg;
    logic                        s1_adv;

    // per-item decode
    logic                        accept;
    logic [1:0]                  in_mode;
    logic                        in_bit;
    logic                        in_idx;
    logic [stdf_pkg::ADDR_W-1:0] in_raddr;
    logic [31:0]                 win_shift;
    logic [31:0]                 merged;
    logic [stdf_pkg::CNT_W-1:0]  eff_count;
    logic [MS-1:0]               need;
    logic [15:0]                 valid_ext;
    logic                        usable;
    logic                        res_valid;
    logic                        res_kind;
    logic [stdf_pkg::SEC_W-1:0]  res_sector;
    logic                        res_rd_ok;
    logic                        res_all;

    assign in_mode   = s_axis_tuser;
    assign in_bit    = s_axis_tdata[0];
    assign in_idx    = s_axis_tdata[1];
    assign in_raddr  = s_axis_tdata[2 +: stdf_pkg::ADDR_W];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign win_shift = {bit_window_reg[30:0], in_bit};
    assign merged    = ((odd_q & stdf_pkg::MFM_DATA) << 1) | (win_shift & stdf_pkg::MFM_DATA);
    assign eff_count = (sector_count_reg > stdf_pkg::CNT_W'(MS)) ?
                       stdf_pkg::CNT_W'(MS) : sector_count_reg;
    assign valid_ext = 16'(valid_reg);
    assign usable    = header_ok_reg && (header_sector_reg < 8'(eff_count)) &&
                       !valid_ext[header_sector_reg[3:0]];
    assign track_waddr = {header_sector_reg[3:0],
                          stdf_pkg::OFS_W'(word_index_reg - 8'd1)};

    always_comb begin
        for (int i = 0; i < MS; i++) begin
            need[i] = (stdf_pkg::CNT_W'(i) < eff_count);
        end
    end

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cylinder_reg     <= '0;
            sector_count_reg <= stdf_pkg::CNT_W'(11);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                stdf_pkg::REG_CYLINDER:     cylinder_reg <= cfg_wdata[stdf_pkg::CYL_W-1:0];
                stdf_pkg::REG_SECTOR_COUNT: sector_count_reg <= cfg_wdata[stdf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next            = phase_reg;
        bit_window_next       = bit_window_reg;
        bit_in_word_next      = bit_in_word_reg;
        word_index_next       = word_index_reg;
        running_sum_next      = running_sum_reg;
        header_sector_next    = header_sector_reg;
        header_ok_next        = header_ok_reg;
        valid_next            = valid_reg;
        bits_since_index_next = bits_since_index_reg;
        sync_offset_next      = sync_offset_reg;
        best_offset_next      = best_offset_reg;
        first_sector_next     = first_sector_reg;
        odd_we     = 1'b0;
        track_we   = 1'b0;
        track_re   = 1'b0;
        res_valid  = 1'b0;
        res_kind   = stdf_pkg::KIND_SECTOR;
        res_sector = '0;
        res_rd_ok  = 1'b0;
        if (accept) begin
            case (in_mode)
                stdf_pkg::MODE_BIT: begin
                    bits_since_index_next = in_idx ? 32'd0 : bits_since_index_reg + 32'd1;
                    bit_window_next = win_shift;
                    case (phase_reg)
                        stdf_pkg::PH_SEARCH: begin
                            if (win_shift == stdf_pkg::SYNC_WORD) begin
                                sync_offset_next = bits_since_index_next - 32'd31;
                                phase_next       = stdf_pkg::PH_TAIL;
                                bit_in_word_next = '0;
                            end
                        end
                        stdf_pkg::PH_TAIL: begin
                            if (bit_in_word_reg == 5'd15) begin
                                bit_in_word_next = '0;
                                word_index_next  = '0;
                                phase_next = (win_shift[15:0] == stdf_pkg::SYNC_TAIL) ?
                                             stdf_pkg::PH_ODD : stdf_pkg::PH_SEARCH;
                            end else begin
                                bit_in_word_next = bit_in_word_reg + 5'd1;
                            end
                        end
                        stdf_pkg::PH_ODD: begin
                            if (bit_in_word_reg == 5'd31) begin
                                bit_in_word_next = '0;
                                odd_we = 1'b1;
                                if (word_index_reg == stdf_pkg::WIDX_W'(stdf_pkg::HALF_LONGS - 1)) begin
                                    phase_next       = stdf_pkg::PH_EVEN;
                                    word_index_next  = '0;
                                    running_sum_next = '0;
                                end else begin
                                    word_index_next = word_index_reg + stdf_pkg::WIDX_W'(1);
                                end
                            end else begin
                                bit_in_word_next = bit_in_word_reg + 5'd1;
                            end
                        end
                        stdf_pkg::PH_EVEN: begin
                            if (bit_in_word_reg == 5'd31) begin
                                bit_in_word_next = '0;
                                if (word_index_reg < stdf_pkg::WIDX_W'(stdf_pkg::HALF_LONGS - 1)) begin
                                    running_sum_next = running_sum_reg + merged;
                                    if (word_index_reg == '0) begin
                                        header_ok_next     = (merged[31:8] == 24'(cylinder_reg));
                                        header_sector_next = merged[7:0];
                                    end else if (usable) begin
                                        track_we = 1'b1;
                                    end
                                    word_index_next = word_index_reg + stdf_pkg::WIDX_W'(1);
                                end else begin
                                    phase_next      = stdf_pkg::PH_SEARCH;
                                    word_index_next = '0;
                                    if (merged == running_sum_reg && usable) begin
                                        valid_next = valid_reg |
                                                     MS'(16'd1 << header_sector_reg[3:0]);
                                        if (best_offset_reg > sync_offset_reg) begin
                                            best_offset_next  = sync_offset_reg;
                                            first_sector_next = header_sector_reg[3:0];
                                        end
                                        res_valid  = 1'b1;
                                        res_kind   = stdf_pkg::KIND_SECTOR;
                                        res_sector = header_sector_reg[3:0];
                                    end
                                end
                            end else begin
                                bit_in_word_next = bit_in_word_reg + 5'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                stdf_pkg::MODE_READ: begin
                    track_re  = 1'b1;
                    res_valid = 1'b1;
                    res_kind  = stdf_pkg::KIND_READ;
                    res_rd_ok = (in_raddr < stdf_pkg::ADDR_W'(stdf_pkg::STORE_LONGS)) &&
                                valid_ext[in_raddr[stdf_pkg::ADDR_W-1 -: 4]];
                end
                stdf_pkg::MODE_NEW_TRACK: begin
                    phase_next            = stdf_pkg::PH_SEARCH;
                    bit_window_next       = '0;
                    bit_in_word_next      = '0;
                    word_index_next       = '0;
                    running_sum_next      = '0;
                    header_sector_next    = '0;
                    header_ok_next        = 1'b0;
                    valid_next            = '0;
                    bits_since_index_next = '0;
                    sync_offset_next      = '0;
                    best_offset_next      = '1;
                    first_sector_next     = '0;
                end
                default: ;
            endcase
        end
        res_all = &(valid_next | ~need);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= stdf_pkg::PH_SEARCH;
            bit_window_reg       <= '0;
            bit_in_word_reg      <= '0;
            word_index_reg       <= '0;
            running_sum_reg      <= '0;
            header_sector_reg    <= '0;
            header_ok_reg        <= 1'b0;
            valid_reg            <= '0;
            bits_since_index_reg <= '0;
            sync_offset_reg      <= '0;
            best_offset_reg      <= '1;
            first_sector_reg     <= '0;
        end else begin
            phase_reg            <= phase_next;
            bit_window_reg       <= bit_window_next;
            bit_in_word_reg      <= bit_in_word_next;
            word_index_reg       <= word_index_next;
            running_sum_reg      <= running_sum_next;
            header_sector_reg    <= header_sector_next;
            header_ok_reg        <= header_ok_next;
            valid_reg            <= valid_next;
            bits_since_index_reg <= bits_since_index_next;
            sync_offset_reg      <= sync_offset_next;
            best_offset_reg      <= best_offset_next;
            first_sector_reg     <= first_sector_next;
        end
    end

    // odd halves: read every cycle at the current long index
    always_ff @(posedge aclk) begin
        if (odd_we) begin
            odd_mem[word_index_reg] <= win_shift;
        end
        odd_q <= odd_mem[word_index_reg];
    end

    always_ff @(posedge aclk) begin
        if (track_we) begin
            track_mem[track_waddr] <= merged;
        end
        if (track_re) begin
            track_q <= track_mem[in_raddr];
        end
    end

    always_comb begin
        if (accept && res_valid) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            s1_kind_reg   <= res_kind;
            s1_sector_reg <= res_sector;
            s1_rd_ok_reg  <= res_rd_ok;
            s1_mask_reg   <= valid_next;
            s1_first_reg  <= first_sector_next;
            s1_all_reg    <= res_all;
        end
        if (s1_adv) begin
            out_kind_reg <= s1_kind_reg;
            out_data_reg <= {4'b0, s1_all_reg, s1_first_reg, s1_mask_reg,
                             (s1_rd_ok_reg ? track_q : 32'd0), s1_sector_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    a_tail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == stdf_pkg::PH_TAIL |-> bit_in_word_reg < 5'd16)
        else $error("tail bit count out of range");

    a_word_index: assert property (@(posedge aclk) disable iff (!aresetn)
        word_index_reg < stdf_pkg::WIDX_W'(stdf_pkg::HALF_LONGS))
        else $error("long index beyond half store");

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        track_we |-> phase_reg == stdf_pkg::PH_EVEN && header_ok_reg &&
                     header_sector_reg < 8'(MS))
        else $error("track store written outside a usable sector");

    a_event_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg == stdf_pkg::KIND_SECTOR |->
        (out_data_reg[46:36] & 11'(16'd1 << out_data_reg[3:0])) != 11'd0)
        else $error("accept event without its valid bit");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with both result registers held");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for sector_track_deframer: sends MFM sector frames,
// track-store reads and control items over s_axis and checks each m_axis
// transfer against an in-bench decoder model. Depends on stdf_pkg.
module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_ROUNDS  = 26;
    localparam int NO_INDEX       = -1000;
    localparam int FILL_ZERO      = 0;
    localparam int FILL_ONES      = 1;
    localparam int FILL_RANDOM    = 2;

    typedef struct packed {
        logic        kind;
        logic [3:0]  sector;
        logic [31:0] data_word;
        logic [10:0] valid_mask;
        logic [3:0]  first_sector;
        logic        all_valid;
    } deframer_answer_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic                             cfg_index;
    logic [stdf_pkg::CFG_W-1:0]       cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [stdf_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic [1:0]                       s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [stdf_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;

    sector_track_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // decoder model state
    logic [7:0]  cyl_cfg;
    logic [3:0]  cnt_cfg;
    logic [31:0] dec_window;
    stdf_pkg::phase_t dec_phase;
    int          dec_bit_cnt;
    int          dec_long_idx;
    logic [31:0] odd_half_mem [stdf_pkg::HALF_LONGS];
    logic [31:0] dec_sum;
    logic [7:0]  dec_hdr_sec;
    logic        dec_hdr_ok;
    logic [31:0] track_mem [stdf_pkg::STORE_LONGS];
    logic [10:0] dec_valid;
    logic [31:0] bits_after_index;
    logic [31:0] dec_sync_ofs;
    logic [31:0] best_sync_ofs;
    logic [3:0]  nearest_sector;

    deframer_answer_t answers_due [$];
    deframer_answer_t checked_answer;
    int mismatch_count = 0;
    int stuck_cycles   = 0;
    int src_idle_pct   = 38;
    int rx_stall_pct   = 38;
    bit rx_hold_req    = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_count();
        return (cnt_cfg > stdf_pkg::MAX_SECTORS) ? stdf_pkg::MAX_SECTORS : int'(cnt_cfg);
    endfunction

    function automatic bit sector_open();
        return dec_hdr_ok && (dec_hdr_sec < eff_count()) && !dec_valid[dec_hdr_sec];
    endfunction

    function automatic bit track_complete();
        logic [10:0] need;
        need = (11'd1 << eff_count()) - 11'd1;
        return (dec_valid & need) == need;
    endfunction

    function automatic void clear_decoder();
        dec_window       = '0;
        dec_phase        = stdf_pkg::PH_SEARCH;
        dec_bit_cnt      = 0;
        dec_long_idx     = 0;
        dec_sum          = '0;
        dec_hdr_sec      = '0;
        dec_hdr_ok       = 1'b0;
        dec_valid        = '0;
        bits_after_index = '0;
        dec_sync_ofs     = '0;
        best_sync_ofs    = '1;
        nearest_sector   = '0;
        foreach (odd_half_mem[i]) odd_half_mem[i] = '0;
        foreach (track_mem[i]) track_mem[i] = '0;
    endfunction

    function automatic bit mfm_decode_item(input logic [1:0] mode, input logic rb,
                                           input logic im, input logic [10:0] ridx,
                                           output deframer_answer_t res);
        logic [31:0] merged;
        res = '0;
        res.valid_mask   = dec_valid;
        res.first_sector = nearest_sector;
        res.all_valid    = track_complete();
        if (mode == stdf_pkg::MODE_READ) begin
            res.kind = stdf_pkg::KIND_READ;
            if (ridx < stdf_pkg::STORE_LONGS && dec_valid[ridx / stdf_pkg::SECTOR_LONGS])
                res.data_word = track_mem[ridx];
            return 1'b1;
        end
        if (mode == stdf_pkg::MODE_NEW_TRACK) begin
            clear_decoder();
            return 1'b0;
        end
        if (mode != stdf_pkg::MODE_BIT)
            return 1'b0;

        bits_after_index = im ? 32'd0 : bits_after_index + 32'd1;
        dec_window = {dec_window[30:0], rb};
        if (dec_phase == stdf_pkg::PH_SEARCH) begin
            if (dec_window == stdf_pkg::SYNC_WORD) begin
                dec_sync_ofs = bits_after_index - 32'd31;
                dec_phase    = stdf_pkg::PH_TAIL;
                dec_bit_cnt  = 0;
            end
            return 1'b0;
        end
        dec_bit_cnt++;
        if (dec_phase == stdf_pkg::PH_TAIL) begin
            if (dec_bit_cnt < 16)
                return 1'b0;
            dec_bit_cnt  = 0;
            dec_long_idx = 0;
            dec_phase    = (dec_window[15:0] == stdf_pkg::SYNC_TAIL) ?
                           stdf_pkg::PH_ODD : stdf_pkg::PH_SEARCH;
            return 1'b0;
        end
        if (dec_bit_cnt < 32)
            return 1'b0;
        dec_bit_cnt = 0;
        if (dec_phase == stdf_pkg::PH_ODD) begin
            odd_half_mem[dec_long_idx] = dec_window;
            dec_long_idx++;
            if (dec_long_idx >= stdf_pkg::HALF_LONGS) begin
                dec_phase    = stdf_pkg::PH_EVEN;
                dec_long_idx = 0;
                dec_sum      = '0;
            end
            return 1'b0;
        end
        merged = ((odd_half_mem[dec_long_idx] & stdf_pkg::MFM_DATA) << 1) |
                 (dec_window & stdf_pkg::MFM_DATA);
        if (dec_long_idx < stdf_pkg::SECTOR_LONGS + 1) begin
            dec_sum += merged;
            if (dec_long_idx == 0) begin
                dec_hdr_ok  = (merged[31:8] == {16'd0, cyl_cfg});
                dec_hdr_sec = merged[7:0];
            end else if (sector_open()) begin
                track_mem[dec_hdr_sec * stdf_pkg::SECTOR_LONGS + dec_long_idx - 1] = merged;
            end
            dec_long_idx++;
            return 1'b0;
        end
        dec_phase    = stdf_pkg::PH_SEARCH;
        dec_long_idx = 0;
        if (merged != dec_sum || !sector_open())
            return 1'b0;
        dec_valid[dec_hdr_sec] = 1'b1;
        if (best_sync_ofs > dec_sync_ofs) begin
            best_sync_ofs  = dec_sync_ofs;
            nearest_sector = dec_hdr_sec[3:0];
        end
        res.kind         = stdf_pkg::KIND_SECTOR;
        res.sector       = dec_hdr_sec[3:0];
        res.valid_mask   = dec_valid;
        res.first_sector = nearest_sector;
        res.all_valid    = track_complete();
        return 1'b1;
    endfunction

    // one s_axis transfer; entered and left at a falling edge
    task automatic send_item(input logic [1:0] mode, input logic rb, input logic im,
                             input logic [10:0] ridx);
        deframer_answer_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {3'b000, ridx, im, rb};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (mfm_decode_item(mode, rb, im, ridx, res))
            answers_due.push_back(res);
        @(negedge aclk);
    endtask

    task automatic send_read(input logic [10:0] ridx);
        send_item(stdf_pkg::MODE_READ, 1'($urandom), 1'($urandom), ridx);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [stdf_pkg::CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        if (idx == stdf_pkg::REG_CYLINDER)
            cyl_cfg = value;
        else
            cnt_cfg = value[3:0];
    endtask

    // pos is 0 at the first sync bit
    task automatic send_bits(input logic [31:0] word, input int nbits, inout int pos,
                             input int index_at);
        for (int i = nbits - 1; i >= 0; i--) begin
            send_item(stdf_pkg::MODE_BIT, word[i],
                      (pos == index_at) || ($urandom_range(4095) == 0), 11'($urandom));
            pos++;
        end
    endtask

    task automatic send_sector_frame(input logic [23:0] hdr_cyl, input logic [7:0] hdr_sec,
                                     input logic [31:0] sum_flip, input logic [15:0] tail,
                                     input int index_at, input int fill);
        logic [31:0] longs [stdf_pkg::HALF_LONGS];
        logic [31:0] sum;
        int noise;
        int pos;
        noise = $urandom_range(12);
        pos = -16 - noise;
        sum = '0;
        longs[0] = {hdr_cyl, hdr_sec};
        for (int i = 1; i <= stdf_pkg::SECTOR_LONGS; i++)
            longs[i] = (fill == FILL_ZERO) ? 32'd0 : (fill == FILL_ONES) ? '1 : $urandom;
        for (int i = 0; i <= stdf_pkg::SECTOR_LONGS; i++)
            sum += longs[i];
        longs[stdf_pkg::HALF_LONGS-1] = sum ^ sum_flip;
        send_bits($urandom, noise, pos, index_at);
        send_bits(32'h0000_aaaa, 16, pos, index_at);
        send_bits(stdf_pkg::SYNC_WORD, 32, pos, index_at);
        send_bits({16'd0, tail}, 16, pos, index_at);
        if (tail != stdf_pkg::SYNC_TAIL)
            return;
        for (int i = 0; i < stdf_pkg::HALF_LONGS; i++)
            send_bits(((longs[i] >> 1) & stdf_pkg::MFM_DATA) | ($urandom & ~stdf_pkg::MFM_DATA),
                      32, pos, index_at);
        for (int i = 0; i < stdf_pkg::HALF_LONGS; i++)
            send_bits((longs[i] & stdf_pkg::MFM_DATA) | ($urandom & ~stdf_pkg::MFM_DATA),
                      32, pos, index_at);
    endtask

    function automatic logic [10:0] pick_read_index();
        if ($urandom_range(3) == 0)
            return 11'($urandom);
        return 11'($urandom_range(stdf_pkg::MAX_SECTORS - 1) * stdf_pkg::SECTOR_LONGS +
                   $urandom_range(stdf_pkg::SECTOR_LONGS - 1));
    endfunction

    task automatic test_empty_track();
        send_read(11'd0);
        send_read(11'd1407);
        send_read(11'd1408);
        send_read(11'h7ff);
        send_item(MODE_UNUSED, 1'b1, 1'b1, 11'h7ff);
        send_item(stdf_pkg::MODE_NEW_TRACK, 1'b0, 1'b0, 11'd0);
        send_item(stdf_pkg::MODE_BIT, 1'b1, 1'b1, 11'h555);
        send_item(stdf_pkg::MODE_BIT, 1'b0, 1'b0, 11'h2aa);
        send_read(11'd640);
        drain();
    endtask

    task automatic test_zero_count();
        write_reg(stdf_pkg::REG_SECTOR_COUNT, 8'd0);
        send_read(11'd0);
        send_sector_frame({16'd0, cyl_cfg}, 8'd0, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_RANDOM);
        send_read(11'd5);
        drain();
    endtask

    task automatic test_accept_and_read();
        write_reg(stdf_pkg::REG_CYLINDER, 8'hff);
        write_reg(stdf_pkg::REG_SECTOR_COUNT, 8'd2);
        send_sector_frame({16'd0, cyl_cfg}, 8'd1, 32'd0, stdf_pkg::SYNC_TAIL, -16, FILL_ONES);
        send_sector_frame({16'd0, cyl_cfg}, 8'd0, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_ZERO);
        send_read(11'd128);
        send_read(11'd255);
        send_read(11'd0);
        send_read(11'd127);
        send_read(11'd256);
        send_read(11'd1408);
        // sector 0 again: must not be accepted nor overwrite stored data
        send_sector_frame({16'd0, cyl_cfg}, 8'd0, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_RANDOM);
        send_read(11'd5);
        drain();
    endtask

    task automatic test_reject_cases();
        send_item(stdf_pkg::MODE_NEW_TRACK, 1'b1, 1'b0, 11'd3);
        write_reg(stdf_pkg::REG_CYLINDER, 8'h5a);
        write_reg(stdf_pkg::REG_SECTOR_COUNT, 8'd4);
        send_sector_frame({16'd0, cyl_cfg}, 8'd3, 32'h0000_0100, stdf_pkg::SYNC_TAIL,
                          NO_INDEX, FILL_RANDOM);
        send_sector_frame({16'd1, cyl_cfg}, 8'd2, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_RANDOM);
        send_sector_frame({16'd0, cyl_cfg}, 8'd1, 32'd0, 16'h2aab, NO_INDEX, FILL_RANDOM);
        send_sector_frame({16'd0, cyl_cfg}, 8'd5, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_RANDOM);
        send_read(11'd384);
        send_read(11'd257);
        drain();
        // count above the maximum acts as the maximum
        write_reg(stdf_pkg::REG_SECTOR_COUNT, 8'hff);
        send_sector_frame({16'd0, cyl_cfg}, 8'd11, 32'd0, stdf_pkg::SYNC_TAIL, NO_INDEX,
                          FILL_RANDOM);
        // index inside the sync word wraps the offset
        send_sector_frame({16'd0, cyl_cfg}, 8'd10, 32'd0, stdf_pkg::SYNC_TAIL, 5, FILL_RANDOM);
        send_sector_frame({16'd0, cyl_cfg}, 8'd2, 32'd0, stdf_pkg::SYNC_TAIL, -16, FILL_RANDOM);
        send_read(11'd1280);
        send_read(11'd1407);
        send_read(11'd300);
        drain();
    endtask

    task automatic test_new_track();
        send_item(stdf_pkg::MODE_NEW_TRACK, 1'b0, 1'b1, 11'h7ff);
        send_read(11'd263);
        send_read(11'd1280);
        drain();
    endtask

    task automatic test_output_holdoff();
        rx_hold_req = 1'b1;
        repeat (60) send_read(pick_read_index());
        drain();
    endtask

    task automatic test_random_track();
        int eff;
        int pick;
        int fresh_n;
        int k;
        int index_at;
        int fill;
        int fresh [stdf_pkg::MAX_SECTORS];
        logic [7:0]  sec;
        logic [23:0] hdr;
        logic [31:0] flip;
        logic [15:0] tail;
        logic [3:0]  cnt;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            src_idle_pct = (round >= 2 && round <= 4) ? 0 : 38;
            rx_stall_pct = src_idle_pct;
            if (round % 6 == 5) begin
                drain();
                pick = $urandom_range(3);
                write_reg(stdf_pkg::REG_CYLINDER,
                          (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom));
                pick = $urandom_range(7);
                cnt = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd1 : (pick == 2) ? 4'd11 :
                      (pick == 3) ? 4'd15 : 4'($urandom_range(10, 1));
                write_reg(stdf_pkg::REG_SECTOR_COUNT, {4'($urandom), cnt});
            end
            if ((eff_count() > 0 && track_complete()) || $urandom_range(9) == 0)
                send_item(stdf_pkg::MODE_NEW_TRACK, 1'($urandom), 1'($urandom), 11'($urandom));

            eff = eff_count();
            fresh_n = 0;
            for (int j = 0; j < eff; j++) begin
                if (!dec_valid[j]) begin
                    fresh[fresh_n] = j;
                    fresh_n++;
                end
            end
            sec  = (fresh_n > 0) ? 8'(fresh[$urandom_range(fresh_n - 1)])
                                 : 8'($urandom_range(stdf_pkg::MAX_SECTORS - 1));
            hdr  = {16'd0, cyl_cfg};
            flip = '0;
            tail = stdf_pkg::SYNC_TAIL;
            pick = $urandom_range(99);
            if (pick >= 95) begin
                tail = stdf_pkg::SYNC_TAIL ^ (16'd1 << $urandom_range(15));
            end else if (pick >= 90) begin
                k = $urandom_range(stdf_pkg::MAX_SECTORS - 1);
                if (dec_valid[k]) sec = 8'(k);
            end else if (pick >= 84) begin
                sec = 8'($urandom_range(255, eff));
            end else if (pick >= 78) begin
                hdr ^= 24'd1 << $urandom_range(23);
            end else if (pick >= 70) begin
                flip = 32'd1 << $urandom_range(31);
            end
            pick = $urandom_range(99);
            index_at = (pick < 30) ? -16 : (pick < 35) ? int'($urandom_range(31)) : NO_INDEX;
            pick = $urandom_range(9);
            fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
            send_sector_frame(hdr, sec, flip, tail, index_at, fill);

            repeat ($urandom_range(55, 35)) send_read(pick_read_index());
            repeat ($urandom_range(8)) send_item(stdf_pkg::MODE_BIT, 1'($urandom),
                                                 $urandom_range(63) == 0, 11'($urandom));
            if ($urandom_range(3) == 0)
                send_item(MODE_UNUSED, 1'($urandom), 1'($urandom), 11'($urandom));
        end
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                $error("result transfer with nothing expected: tuser %0b tdata 0x%0h",
                       m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                checked_answer = answers_due.pop_front();
                check_field("kind", checked_answer.kind, m_axis_tuser);
                check_field("sector", checked_answer.sector, m_axis_tdata[3:0]);
                check_field("data_word", checked_answer.data_word, m_axis_tdata[35:4]);
                check_field("valid_mask", checked_answer.valid_mask, m_axis_tdata[46:36]);
                check_field("first_sector", checked_answer.first_sector, m_axis_tdata[50:47]);
                check_field("all_valid", checked_answer.all_valid, m_axis_tdata[51]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = stdf_pkg::REG_CYLINDER;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stdf_pkg::MODE_BIT;
        cyl_cfg       = 8'd0;
        cnt_cfg       = 4'd11;
        clear_decoder();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_track();
        test_zero_count();
        test_accept_and_read();
        test_reject_cases();
        test_new_track();
        test_output_holdoff();
        test_random_track();

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && answers_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/stdf_pkg.sv
rtl/core/sector_track_deframer.sv
tb/tb_top.sv
